// File: hw/rtl/mprs_pkg.sv
// Shared types and constants for the max pool and ReLU stream unit.
package mprs_pkg;

	localparam int PIXEL_BITS    = 16;
	localparam int MAX_OUT_WIDTH = 1024;
	localparam int SLOT_BITS     = $clog2(MAX_OUT_WIDTH);
	localparam int ROW_BITS      = 16;
	localparam int POOL_BITS     = 4;
	localparam int WIDTH_BITS    = 11;
	localparam int VALUE_BITS    = 15;
	localparam int ADDR_BITS     = 4;

	localparam logic [POOL_BITS-1:0]  POOL_MAX    = 4'd8;
	localparam logic [WIDTH_BITS-1:0] WIDTH_LIMIT =
		(MAX_OUT_WIDTH > 1024) ? 11'd1024 : WIDTH_BITS'(MAX_OUT_WIDTH);

	// Register indexes on the configuration port
	localparam logic [1:0] REG_POOL_SIZE  = 2'd0;
	localparam logic [1:0] REG_OUT_WIDTH  = 2'd1;
	localparam logic [1:0] REG_OUT_HEIGHT = 2'd2;

	// Effective (clamped) configuration, already reduced to end counts
	typedef struct packed {
		logic [2:0]           pool_m1;
		logic [SLOT_BITS-1:0] width_m1;
		logic [ROW_BITS-1:0]  height_m1;
	} cfg_t;

	// Window position of one accepted pixel
	typedef struct packed {
		logic [SLOT_BITS-1:0] slot;
		logic [ROW_BITS-1:0]  row;
		logic                 first;
		logic                 emit;
		logic                 last;
	} win_info_t;

	// Datapath status seen by the top level
	typedef struct packed {
		logic v_s1;
		logic emit_s1;
		logic adv_s1;
	} dp_status_t;

endpackage

// File: hw/rtl/mprs_cfg_regs.sv
// APB-style configuration registers with clamping to effective values.
module mprs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mprs_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output mprs_pkg::cfg_t                 cfg
);

	logic [mprs_pkg::POOL_BITS-1:0]  pool_q;
	logic [mprs_pkg::WIDTH_BITS-1:0] width_q;
	logic [mprs_pkg::ROW_BITS-1:0]   height_q;
	logic [1:0]                      idx;
	logic                            wr_en;
	logic [mprs_pkg::POOL_BITS-1:0]  pool_eff;
	logic [mprs_pkg::WIDTH_BITS-1:0] width_eff;
	logic [mprs_pkg::ROW_BITS-1:0]   height_eff;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;

	// Capture register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q   <= 4'd2;
			width_q  <= 11'd1;
			height_q <= 16'd1;
		end else if (wr_en) begin
			case (idx)
				mprs_pkg::REG_POOL_SIZE:  pool_q   <= pwdata[3:0];
				mprs_pkg::REG_OUT_WIDTH:  width_q  <= pwdata[10:0];
				mprs_pkg::REG_OUT_HEIGHT: height_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the raw register values
	always_comb begin
		case (idx)
			mprs_pkg::REG_POOL_SIZE:  prdata = {28'd0, pool_q};
			mprs_pkg::REG_OUT_WIDTH:  prdata = {21'd0, width_q};
			mprs_pkg::REG_OUT_HEIGHT: prdata = {16'd0, height_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// Clamp to the supported ranges and form end counts
	always_comb begin
		if (pool_q == 4'd0)
			pool_eff = 4'd1;
		else if (pool_q > mprs_pkg::POOL_MAX)
			pool_eff = mprs_pkg::POOL_MAX;
		else
			pool_eff = pool_q;

		if (width_q == 11'd0)
			width_eff = 11'd1;
		else if (width_q > mprs_pkg::WIDTH_LIMIT)
			width_eff = mprs_pkg::WIDTH_LIMIT;
		else
			width_eff = width_q;

		height_eff = (height_q == 16'd0) ? 16'd1 : height_q;

		cfg.pool_m1   = 3'(pool_eff - 4'd1);
		cfg.width_m1  = mprs_pkg::SLOT_BITS'(width_eff - 11'd1);
		cfg.height_m1 = height_eff - 16'd1;
	end

endmodule

// File: hw/rtl/mprs_win_ctrl.sv
// Window position counters advanced once per accepted pixel.
module mprs_win_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mprs_pkg::cfg_t        cfg,
	input  logic                  accept,
	output mprs_pkg::win_info_t   info
);

	logic [2:0]                     col_in_q;
	logic [2:0]                     row_in_q;
	logic [mprs_pkg::SLOT_BITS-1:0] wcol_q;
	logic [mprs_pkg::ROW_BITS-1:0]  wrow_q;
	logic                           col_end;
	logic                           row_end;
	logic                           wcol_end;
	logic                           wrow_end;

	// A counter at or past its end counts as at its end
	assign col_end  = col_in_q >= cfg.pool_m1;
	assign row_end  = row_in_q >= cfg.pool_m1;
	assign wcol_end = wcol_q >= cfg.width_m1;
	assign wrow_end = wrow_q >= cfg.height_m1;

	always_comb begin
		info.slot  = wcol_q;
		info.row   = wrow_q;
		info.first = (col_in_q == 3'd0) && (row_in_q == 3'd0);
		info.emit  = col_end && row_end;
		info.last  = wcol_end && wrow_end;
	end

	// Advance the nested counters on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_in_q <= 3'd0;
			row_in_q <= 3'd0;
			wcol_q   <= '0;
			wrow_q   <= '0;
		end else if (accept) begin
			if (!col_end) begin
				col_in_q <= col_in_q + 3'd1;
			end else begin
				col_in_q <= 3'd0;
				if (!wcol_end) begin
					wcol_q <= wcol_q + mprs_pkg::SLOT_BITS'(1);
				end else begin
					wcol_q <= '0;
					if (!row_end) begin
						row_in_q <= row_in_q + 3'd1;
					end else begin
						row_in_q <= 3'd0;
						wrow_q   <= wrow_end ? '0 : wrow_q + 16'd1;
					end
				end
			end
		end
	end

endmodule

// File: hw/rtl/mprs_pool_dp.sv
// Running-maximum store, compare stage and output register.
module mprs_pool_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic signed [mprs_pkg::PIXEL_BITS-1:0] pixel,
	input  mprs_pkg::win_info_t                    info,
	input  logic                                   out_stall,
	output logic                                   out_valid,
	output logic [mprs_pkg::VALUE_BITS-1:0]        pooled_value,
	output logic [mprs_pkg::SLOT_BITS-1:0]         out_col,
	output logic [mprs_pkg::ROW_BITS-1:0]          out_row,
	output logic                                   frame_last,
	output logic                                   in_stall,
	output mprs_pkg::dp_status_t                   st
);

	logic signed [mprs_pkg::PIXEL_BITS-1:0] store_mem [mprs_pkg::MAX_OUT_WIDTH];
	logic signed [mprs_pkg::PIXEL_BITS-1:0] rd_q;
	logic signed [mprs_pkg::PIXEL_BITS-1:0] px_s1;
	mprs_pkg::win_info_t                    info_s1;
	logic                                   v_s1;
	logic [mprs_pkg::SLOT_BITS-1:0]         fwd_slot_q;
	logic signed [mprs_pkg::PIXEL_BITS-1:0] fwd_val_q;
	logic                                   fwd_valid_q;
	logic signed [mprs_pkg::PIXEL_BITS-1:0] prev_max;
	logic signed [mprs_pkg::PIXEL_BITS-1:0] new_max;
	logic                                   out_free;
	logic                                   adv_s1;

	// Stage 1 moves on unless its result finds the output register full and stalled
	assign out_free = !out_valid || !out_stall;
	assign adv_s1   = v_s1 && (!info_s1.emit || out_free);
	assign in_stall = v_s1 && !adv_s1;

	assign st.v_s1    = v_s1;
	assign st.emit_s1 = info_s1.emit;
	assign st.adv_s1  = adv_s1;

	// Read the store slot as the pixel enters
	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= store_mem[info.slot];
	end

	// Write back the updated maximum as stage 1 retires
	always_ff @(posedge clk) begin
		if (adv_s1)
			store_mem[info_s1.slot] <= new_max;
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			info_s1 <= info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (accept)
			v_s1 <= 1'b1;
		else if (adv_s1)
			v_s1 <= 1'b0;
	end

	// Hold the last write so a read that raced it sees the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (adv_s1) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fwd_slot_q <= info_s1.slot;
			fwd_val_q  <= new_max;
		end
	end

	// Merge the pixel into the window maximum
	always_comb begin
		prev_max = (fwd_valid_q && fwd_slot_q == info_s1.slot) ? fwd_val_q : rd_q;
		if (info_s1.first || px_s1 > prev_max)
			new_max = px_s1;
		else
			new_max = prev_max;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv_s1 && info_s1.emit)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && info_s1.emit) begin
			pooled_value <= (new_max > 0) ? new_max[mprs_pkg::VALUE_BITS-1:0] : '0;
			out_col      <= info_s1.slot;
			out_row      <= info_s1.row;
			frame_last   <= info_s1.last;
		end
	end

endmodule

// File: hw/rtl/max_pool_relu_stream_unit.sv
// Top level of the streaming max pool and ReLU unit.
// Takes one signed Q8.8 pixel per cycle, unless stalled, in raster order and issues one
// result, the window maximum clamped at zero, on the last pixel of each pool_size x pool_size
// window. A pixel passes through the compare stage, where the store read issued on entry is
// merged with the pixel, then the result sits in the output register; sustained rate is one
// pixel per clock without stalls. The rate is set by the per-column maximum store, a two-port
// memory that is read as a pixel enters and written as it leaves the compare stage; a read
// that meets the write to the same slot takes the forwarded last write. The input stalls
// only when a result is waiting in the compare stage and the output register is full and
// stalled. The store needs no clearing after reset: every window's first pixel loads its slot.
module max_pool_relu_stream_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [mprs_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [mprs_pkg::PIXEL_BITS-1:0] pixel,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [mprs_pkg::VALUE_BITS-1:0]        pooled_value,
	output logic [mprs_pkg::SLOT_BITS-1:0]         out_col,
	output logic [mprs_pkg::ROW_BITS-1:0]          out_row,
	output logic                                   frame_last
);

	mprs_pkg::cfg_t       cfg;
	mprs_pkg::win_info_t  info;
	mprs_pkg::dp_status_t st;
	logic                 accept;

	assign accept = in_valid && !in_stall;

	mprs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mprs_win_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.info   (info)
	);

	mprs_pool_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pixel        (pixel),
		.info         (info),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.pooled_value (pooled_value),
		.out_col      (out_col),
		.out_row      (out_row),
		.frame_last   (frame_last),
		.in_stall     (in_stall),
		.st           (st)
	);

	// Input backpressure only comes from a full, stalled output with a result behind it
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (st.v_s1 && st.emit_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// A new result appears only when the compare stage retires one
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |=> (!out_valid || $past(st.adv_s1 && st.emit_s1)))
		else $error("result shown without a retiring window");

	// Compare stage never retires an empty slot
	a_adv_valid: assert property (@(posedge clk) disable iff (!arst_n)
		st.adv_s1 |-> st.v_s1)
		else $error("compare stage advanced while empty");

endmodule
